[rtl/core/dfs_path_finder_core_defines.svh]
// Assertion macros used by the checker of the path finder core.
`ifndef DFS_PATH_FINDER_CORE_DEFINES_SVH
`define DFS_PATH_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dpf_pkg.sv]
// Package of the path finder core: widths, step codes, microcode and control types.
`timescale 1ns / 1ps
`default_nettype none

package dpf_pkg;

    localparam int DPF_NODES = 32;
    localparam int FIELD_W   = 5;
    localparam int COUNT_W   = 6;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 6'd32;

    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE       = 4'd0;
    localparam step_t STEP_EDGE_RD    = 4'd1;
    localparam step_t STEP_EDGE_WR    = 4'd2;
    localparam step_t STEP_Q_START    = 4'd3;
    localparam step_t STEP_ROW        = 4'd4;
    localparam step_t STEP_DECIDE     = 4'd5;
    localparam step_t STEP_PUSH       = 4'd6;
    localparam step_t STEP_PATH_START = 4'd7;
    localparam step_t STEP_PATH_CHK   = 4'd8;
    localparam step_t STEP_PATH_EMIT  = 4'd9;
    localparam step_t STEP_PRED_WAIT  = 4'd10;
    localparam step_t STEP_EMIT_LAST  = 4'd11;
    localparam step_t STEP_POP_RD     = 4'd12;
    localparam step_t STEP_POP_WAIT   = 4'd13;
    localparam step_t STEP_NOPATH     = 4'd14;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_EDGE_RD,
        OP_EDGE_WR,
        OP_Q_START,
        OP_ROW,
        OP_DECIDE,
        OP_PUSH,
        OP_PATH_START,
        OP_EMIT_NODE,
        OP_PRED_WAIT,
        OP_EMIT_SRC,
        OP_POP_RD,
        OP_POP_WAIT,
        OP_EMIT_NONE
    } op_t;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_REQ,
        HOLD_OUT_BUSY
    } hold_t;

    typedef enum logic [2:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_QUERY,
        JMP_BAD_RANGE,
        JMP_MISS,
        JMP_NOT_DST,
        JMP_PATH_END,
        JMP_STACK_EMPTY
    } jmp_t;

    typedef struct packed {
        op_t   op;
        hold_t hold;
        jmp_t  jmp;
        step_t target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic go;
    } ctrl_t;

    typedef struct packed {
        logic req_valid;
        logic req_query;
        logic out_busy;
        logic bad_range;
        logic miss;
        logic not_dst;
        logic path_end;
        logic stack_empty;
    } status_t;

    // The control store. A step that is held repeats; otherwise a taken jump goes to
    // the target and anything else falls through to the next step.
    function automatic uword_t ucode(input step_t pc);
        uword_t w;
        unique case (pc)
            STEP_IDLE:       w = '{OP_ACCEPT,     HOLD_NO_REQ,   JMP_QUERY,       STEP_Q_START};
            STEP_EDGE_RD:    w = '{OP_EDGE_RD,    HOLD_NONE,     JMP_BAD_RANGE,   STEP_IDLE};
            STEP_EDGE_WR:    w = '{OP_EDGE_WR,    HOLD_NONE,     JMP_ALWAYS,      STEP_IDLE};
            STEP_Q_START:    w = '{OP_Q_START,    HOLD_NONE,     JMP_BAD_RANGE,   STEP_NOPATH};
            STEP_ROW:        w = '{OP_ROW,        HOLD_NONE,     JMP_NEVER,       STEP_IDLE};
            STEP_DECIDE:     w = '{OP_DECIDE,     HOLD_NONE,     JMP_MISS,        STEP_POP_RD};
            STEP_PUSH:       w = '{OP_PUSH,       HOLD_NONE,     JMP_NOT_DST,     STEP_ROW};
            STEP_PATH_START: w = '{OP_PATH_START, HOLD_NONE,     JMP_NEVER,       STEP_IDLE};
            STEP_PATH_CHK:   w = '{OP_NOP,        HOLD_NONE,     JMP_PATH_END,    STEP_EMIT_LAST};
            STEP_PATH_EMIT:  w = '{OP_EMIT_NODE,  HOLD_OUT_BUSY, JMP_NEVER,       STEP_IDLE};
            STEP_PRED_WAIT:  w = '{OP_PRED_WAIT,  HOLD_NONE,     JMP_ALWAYS,      STEP_PATH_CHK};
            STEP_EMIT_LAST:  w = '{OP_EMIT_SRC,   HOLD_OUT_BUSY, JMP_ALWAYS,      STEP_IDLE};
            STEP_POP_RD:     w = '{OP_POP_RD,     HOLD_NONE,     JMP_STACK_EMPTY, STEP_NOPATH};
            STEP_POP_WAIT:   w = '{OP_POP_WAIT,   HOLD_NONE,     JMP_ALWAYS,      STEP_ROW};
            STEP_NOPATH:     w = '{OP_EMIT_NONE,  HOLD_OUT_BUSY, JMP_ALWAYS,      STEP_IDLE};
            default:         w = '{OP_NOP,        HOLD_NONE,     JMP_ALWAYS,      STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/dpf_req_if.sv]
// Request channel of the path finder core: valid, ready and the request fields.
`timescale 1ns / 1ps
`default_nettype none

interface dpf_req_if
    import dpf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [FIELD_W-1:0] from_node;
    logic [FIELD_W-1:0] to_node;
    logic               edge_present;

    modport source (
        output valid,
        output cmd,
        output from_node,
        output to_node,
        output edge_present,
        input  ready
    );

    modport sink (
        input  valid,
        input  cmd,
        input  from_node,
        input  to_node,
        input  edge_present,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/dpf_res_if.sv]
// Result channel of the path finder core: valid, ready and the result fields.
`timescale 1ns / 1ps
`default_nettype none

interface dpf_res_if
    import dpf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] path_node;
    logic               found;
    logic               last;

    modport source (
        output valid,
        output path_node,
        output found,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  path_node,
        input  found,
        input  last,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/dpf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/dpf_sequencer.sv]
// Microcode sequencer: step counter, control store lookup and jump evaluation.
`timescale 1ns / 1ps
`default_nettype none

module dpf_sequencer
    import dpf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctrl_t   ctrl
);

    step_t  pc_reg;
    step_t  pc_next;
    uword_t uw;
    logic   held;
    logic   take;

    assign uw = ucode(pc_reg);

    always_comb
    begin
        unique case (uw.hold)
            HOLD_NONE:     held = 1'b0;
            HOLD_NO_REQ:   held = !status.req_valid;
            HOLD_OUT_BUSY: held = status.out_busy;
            default:       held = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (uw.jmp)
            JMP_NEVER:       take = 1'b0;
            JMP_ALWAYS:      take = 1'b1;
            JMP_QUERY:       take = status.req_query;
            JMP_BAD_RANGE:   take = status.bad_range;
            JMP_MISS:        take = status.miss;
            JMP_NOT_DST:     take = status.not_dst;
            JMP_PATH_END:    take = status.path_end;
            JMP_STACK_EMPTY: take = status.stack_empty;
        endcase
    end

    always_comb
    begin
        if (held)
        begin
            pc_next = pc_reg;
        end
        else if (take)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + step_t'(1);
        end
    end

    assign ctrl.op = uw.op;
    assign ctrl.go = !held;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/dpf_datapath.sv]
// Datapath of the path finder: adjacency, stack and predecessor memories, visited marks
// and the neighbour search, driven by the control word of the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dpf_datapath
    import dpf_pkg::*;
#(
    parameter int NODES = DPF_NODES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_t                  ctrl,
    output status_t                status,
    input  logic [$clog2(NODES):0] limit,
    dpf_req_if.sink                req,
    dpf_res_if.source              res
);

    localparam int IW = $clog2(NODES);
    localparam int CW = IW + 1;
    localparam int SW = IW + CW;
    localparam logic [6:0]       NODES7 = 7'(NODES);
    localparam logic [NODES-1:0] BIT0   = NODES'(1);

    // Request latched at acceptance.
    logic [FIELD_W-1:0] a_reg;
    logic [FIELD_W-1:0] b_reg;
    logic               e_reg;

    // Search state.
    logic [IW-1:0]    v_reg;
    logic [CW-1:0]    next_reg;
    logic [CW-1:0]    top_reg;
    logic [IW-1:0]    w_reg;
    logic             hit_reg;
    logic [NODES-1:0] visited_reg;
    logic [NODES-1:0] row_valid_reg;
    logic             row_vld_rd_reg;

    // Path walk.
    logic [IW-1:0] cur_reg;
    logic [CW-1:0] guard_reg;

    // Result register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [FIELD_W-1:0] out_node_reg;
    logic               out_found_reg;
    logic               out_last_reg;

    logic [IW-1:0]    src_idx;
    logic [IW-1:0]    dst_idx;
    logic             in_range;
    logic [CW-1:0]    top_m1;
    logic             full;
    logic             push_ok;
    logic             accept;
    logic             emit;
    logic [6:0]       cur_ext;
    logic [NODES-1:0] adj_row;
    logic [NODES-1:0] cand;
    logic [NODES-1:0] edge_row;
    logic             found_any;
    logic [IW-1:0]    first;

    logic             adj_we;
    logic [IW-1:0]    adj_raddr;
    logic [NODES-1:0] adj_rdata;
    logic             stk_we;
    logic [IW-1:0]    stk_waddr;
    logic [SW-1:0]    stk_wdata;
    logic [SW-1:0]    stk_rdata;
    logic [IW-1:0]    stk_rd_node;
    logic [CW-1:0]    stk_rd_next;
    logic             pred_we;
    logic [IW-1:0]    pred_rdata;

    assign src_idx  = IW'(a_reg);
    assign dst_idx  = IW'(b_reg);
    assign in_range = (7'(a_reg) < NODES7) && (7'(b_reg) < NODES7);
    assign top_m1   = top_reg - CW'(1);
    assign full     = (top_reg == CW'(NODES));
    assign push_ok  = (w_reg != dst_idx) && !full;
    assign cur_ext  = 7'(cur_reg);

    assign stk_rd_node = stk_rdata[SW-1:CW];
    assign stk_rd_next = stk_rdata[CW-1:0];

    // A row never written since reset reads as empty.
    assign adj_row = row_vld_rd_reg ? adj_rdata : '0;

    // Lowest unvisited neighbour at or above the resume point and below the node limit.
    always_comb
    begin
        cand      = adj_row & ~visited_reg;
        found_any = 1'b0;
        first     = '0;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if (cand[i] && (CW'(i) >= next_reg) && (CW'(i) < limit))
            begin
                found_any = 1'b1;
                first     = IW'(i);
            end
        end
    end

    always_comb
    begin
        edge_row          = adj_row;
        edge_row[dst_idx] = e_reg;
    end

    assign adj_we  = (ctrl.op == OP_EDGE_WR);
    assign pred_we = (ctrl.op == OP_DECIDE) && hit_reg;

    always_comb
    begin
        unique case (ctrl.op) inside
            OP_EDGE_RD, OP_Q_START: adj_raddr = src_idx;
            OP_POP_WAIT:            adj_raddr = stk_rd_node;
            OP_PUSH:                adj_raddr = full ? v_reg : w_reg;
            default:                adj_raddr = v_reg;
        endcase
    end

    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = top_m1[IW-1:0];
        stk_wdata = {v_reg, CW'(w_reg) + CW'(1)};
        unique case (ctrl.op)
            OP_Q_START:
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = {src_idx, CW'(0)};
            end
            OP_DECIDE:
            begin
                stk_we = hit_reg;
            end
            OP_PUSH:
            begin
                stk_we    = push_ok;
                stk_waddr = top_reg[IW-1:0];
                stk_wdata = {w_reg, CW'(0)};
            end
            default:
            begin
                stk_we = 1'b0;
            end
        endcase
    end

    dpf_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (src_idx),
        .wdata (edge_row),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    dpf_ram #(
        .WIDTH (SW),
        .DEPTH (NODES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (top_m1[IW-1:0]),
        .rdata (stk_rdata)
    );

    dpf_ram #(
        .WIDTH (IW),
        .DEPTH (NODES)
    ) u_pred_ram (
        .clk   (clk),
        .we    (pred_we),
        .waddr (w_reg),
        .wdata (v_reg),
        .raddr (cur_reg),
        .rdata (pred_rdata)
    );

    assign req.ready = (ctrl.op == OP_ACCEPT);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        unique case (ctrl.op) inside
            OP_EMIT_NODE, OP_EMIT_SRC, OP_EMIT_NONE: emit = ctrl.go;
            default:                                 emit = 1'b0;
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg        <= '0;
            visited_reg    <= '0;
            row_valid_reg  <= '0;
            row_vld_rd_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            row_vld_rd_reg <= row_valid_reg[adj_raddr];
            case (ctrl.op)
                OP_EDGE_WR:
                begin
                    row_valid_reg[src_idx] <= 1'b1;
                end
                OP_Q_START:
                begin
                    top_reg     <= CW'(1);
                    visited_reg <= BIT0 << src_idx;
                end
                OP_DECIDE:
                begin
                    if (hit_reg)
                    begin
                        visited_reg <= visited_reg | (BIT0 << w_reg);
                    end
                    else
                    begin
                        top_reg <= top_m1;
                    end
                end
                OP_PUSH:
                begin
                    if (push_ok)
                    begin
                        top_reg <= top_reg + CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_ACCEPT:
            begin
                if (accept)
                begin
                    a_reg <= req.from_node;
                    b_reg <= req.to_node;
                    e_reg <= req.edge_present;
                end
            end
            OP_Q_START:
            begin
                v_reg    <= src_idx;
                next_reg <= '0;
            end
            OP_ROW:
            begin
                hit_reg <= found_any;
                w_reg   <= first;
            end
            OP_PUSH:
            begin
                // With the stack full the node stays on top and resumes past w.
                if (full)
                begin
                    next_reg <= CW'(w_reg) + CW'(1);
                end
                else
                begin
                    v_reg    <= w_reg;
                    next_reg <= '0;
                end
            end
            OP_POP_WAIT:
            begin
                v_reg    <= stk_rd_node;
                next_reg <= stk_rd_next;
            end
            OP_PATH_START:
            begin
                cur_reg   <= dst_idx;
                guard_reg <= '0;
            end
            OP_PRED_WAIT:
            begin
                cur_reg   <= pred_rdata;
                guard_reg <= guard_reg + CW'(1);
            end
            OP_EMIT_NODE:
            begin
                if (ctrl.go)
                begin
                    out_node_reg  <= cur_ext[FIELD_W-1:0];
                    out_found_reg <= 1'b1;
                    out_last_reg  <= 1'b0;
                end
            end
            OP_EMIT_SRC:
            begin
                if (ctrl.go)
                begin
                    out_node_reg  <= a_reg;
                    out_found_reg <= 1'b1;
                    out_last_reg  <= 1'b1;
                end
            end
            OP_EMIT_NONE:
            begin
                if (ctrl.go)
                begin
                    out_node_reg  <= '0;
                    out_found_reg <= 1'b0;
                    out_last_reg  <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid     = out_valid_reg;
    assign res.path_node = out_node_reg;
    assign res.found     = out_found_reg;
    assign res.last      = out_last_reg;

    assign status.req_valid   = req.valid;
    assign status.req_query   = (req.cmd == CMD_QUERY);
    assign status.out_busy    = out_valid_reg && !res.ready;
    assign status.bad_range   = !in_range;
    assign status.miss        = !hit_reg;
    assign status.not_dst     = (w_reg != dst_idx);
    assign status.path_end    = (cur_reg == src_idx) || (guard_reg == CW'(NODES));
    assign status.stack_empty = (top_reg == '0);

endmodule

`default_nettype wire

[rtl/core/dfs_path_finder_core.sv]
// Top level of the depth-first path finder: node count register, sequencer and datapath.
// An edge write reads the source row and writes it back with the new bit, then returns to idle.
// A query searches depth first from the source, stepping back through the stack at a dead end,
// then emits the path from the destination back to the source, or a single no-path result.
// Reset empties the graph through per-row valid flops, with no clearing pass, and sets
// node_count to 32; the block is ready for a request as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module dfs_path_finder_core
    import dpf_pkg::*;
#(
    parameter int NODES = DPF_NODES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    dpf_req_if.sink            req,
    dpf_res_if.source          res
);

    localparam int CW = $clog2(NODES) + 1;

    logic [COUNT_W-1:0] node_count_reg;
    logic [6:0]         nc_ext;
    logic [CW-1:0]      limit;
    ctrl_t              ctrl;
    status_t            status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_data;
        end
    end

    // Counts above the graph size act as the graph size.
    assign nc_ext = 7'(node_count_reg);
    assign limit  = (nc_ext < 7'(NODES)) ? CW'(nc_ext) : CW'(NODES);

    dpf_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    dpf_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .status (status),
        .limit  (limit),
        .req    (req),
        .res    (res)
    );

endmodule

`default_nettype wire

[rtl/core/dpf_checker.sv]
// Port-level checker of the path finder core and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "dfs_path_finder_core_defines.svh"

module dpf_checker
    import dpf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [FIELD_W-1:0] res_path_node,
    input logic               res_found,
    input logic               res_last
);

    // A stalled result keeps its value.
    `DPF_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_path_node) && $stable(res_found) && $stable(res_last), "stalled result changed")

    // The no-path result is a single, final result on node zero.
    `DPF_ASSERT_SAME(a_nopath_form, clk, rst_n, res_valid && !res_found, res_last && (res_path_node == '0), "malformed no-path result")

    // Only a found path has results before its last one.
    `DPF_ASSERT_SAME(a_inner_found, clk, rst_n, res_valid && !res_last, res_found, "non-final result without a path")

    // One request is worked on at a time.
    `DPF_ASSERT_NEXT(a_one_request, clk, rst_n, req_valid && req_ready, !req_ready, "request accepted while busy")

endmodule

bind dfs_path_finder_core dpf_checker u_dpf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_path_node (res.path_node),
    .res_found     (res.found),
    .res_last      (res.last)
);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench of the depth-first path finder core with its own path predictor.
`timescale 1ns / 1ps

module tb;
    import dpf_pkg::*;

    localparam int RANDOM_ITEMS  = 448;
    localparam int PHASES        = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam bit CHECK_FIXED   = 1'b1;
    localparam bit CHECK_MODEL   = 1'b0;

    typedef struct packed {
        logic [FIELD_W-1:0] path_node;
        logic               found;
        logic               last;
    } path_step_t;

    localparam path_step_t NO_PATH = '{path_node: '0, found: 1'b0, last: 1'b1};

    typedef enum logic {
        ROW_REQUEST,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               cmd;
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] dst;
        logic               present;
        logic [COUNT_W-1:0] limit;
        logic               fixed;
        path_step_t         result;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 29;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_REQUEST, CMD_QUERY, 5'd0,  5'd31, 1'b0, 6'd0,  CHECK_FIXED, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd5,  5'd5,  1'b0, 6'd0,  CHECK_FIXED, NO_PATH},
        '{ROW_REQUEST, CMD_EDGE,  5'd0,  5'd31, 1'b1, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd0,  5'd31, 1'b0, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_EDGE,  5'd31, 5'd0,  1'b1, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd31, 5'd0,  1'b1, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd0,  5'd0,  1'b0, 6'd0,  CHECK_FIXED, NO_PATH},
        '{ROW_REQUEST, CMD_EDGE,  5'd0,  5'd31, 1'b0, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd0,  5'd31, 1'b0, 6'd0,  CHECK_FIXED, NO_PATH},
        '{ROW_REQUEST, CMD_EDGE,  5'd31, 5'd31, 1'b1, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd31, 5'd31, 1'b1, 6'd0,  CHECK_FIXED, NO_PATH},
        '{ROW_REQUEST, CMD_EDGE,  5'd1,  5'd2,  1'b1, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_EDGE,  5'd2,  5'd0,  1'b1, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_EDGE,  5'd2,  5'd3,  1'b1, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_EDGE,  5'd3,  5'd30, 1'b1, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_EDGE,  5'd1,  5'd30, 1'b1, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd1,  5'd30, 1'b0, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd30, 5'd1,  1'b0, 6'd0,  CHECK_FIXED, NO_PATH},
        '{ROW_CONFIG,  CMD_EDGE,  5'd0,  5'd0,  1'b0, 6'd4,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd1,  5'd30, 1'b0, 6'd0,  CHECK_FIXED, NO_PATH},
        '{ROW_REQUEST, CMD_EDGE,  5'd30, 5'd2,  1'b1, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd30, 5'd3,  1'b0, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_CONFIG,  CMD_EDGE,  5'd0,  5'd0,  1'b0, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd1,  5'd2,  1'b0, 6'd0,  CHECK_FIXED, NO_PATH},
        '{ROW_CONFIG,  CMD_EDGE,  5'd0,  5'd0,  1'b0, 6'd63, CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd1,  5'd30, 1'b0, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_CONFIG,  CMD_EDGE,  5'd0,  5'd0,  1'b0, NODE_COUNT_RST, CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd31, 5'd30, 1'b0, 6'd0,  CHECK_MODEL, NO_PATH},
        '{ROW_REQUEST, CMD_QUERY, 5'd30, 5'd0,  1'b0, 6'd0,  CHECK_MODEL, NO_PATH}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    dpf_req_if req_ch ();
    dpf_res_if res_ch ();

    dfs_path_finder_core #(
        .NODES (DPF_NODES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .res      (res_ch)
    );

    // Predictor state: the graph, the predecessor of each node and the node count.
    logic [DPF_NODES-1:0] adjacency_rows [DPF_NODES];
    logic [FIELD_W-1:0]   pred_node [DPF_NODES];
    logic [COUNT_W-1:0]   node_limit;

    path_step_t path_expected [$];
    int         error_count;
    bit         send_calm;

    logic [COUNT_W-1:0] phase_limits [PHASES];

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $realtime, msg);
        error_count++;
    endtask

    // Runs the depth-first search on the predictor's graph and queues the path it yields, or the no-path result.
    task automatic predict_path(input logic [FIELD_W-1:0] src, input logic [FIELD_W-1:0] dst);
        logic [DPF_NODES-1:0] seen;
        logic [FIELD_W-1:0]   stk_node [DPF_NODES];
        int                   stk_next [DPF_NODES];
        int                   depth;
        int                   top;
        int                   span;
        int                   v;
        int                   w;
        int                   guard;
        bit                   hit;
        bit                   pushed;
        span = (node_limit < DPF_NODES) ? int'(node_limit) : DPF_NODES;
        seen = '0;
        seen[src] = 1'b1;
        stk_node[0] = src;
        stk_next[0] = 0;
        depth = 1;
        hit = 1'b0;
        while (depth > 0 && !hit)
        begin
            top = depth - 1;
            v = stk_node[top];
            pushed = 1'b0;
            w = stk_next[top];
            while (w < span && !pushed)
            begin
                if (adjacency_rows[v][w] && !seen[w])
                begin
                    seen[w] = 1'b1;
                    pred_node[w] = v[FIELD_W-1:0];
                    stk_next[top] = w + 1;
                    if (w == int'(dst))
                    begin
                        hit = 1'b1;
                    end
                    else if (depth < DPF_NODES)
                    begin
                        stk_node[depth] = w[FIELD_W-1:0];
                        stk_next[depth] = 0;
                        depth++;
                    end
                    pushed = 1'b1;
                end
                w++;
            end
            if (!pushed)
            begin
                depth--;
            end
        end
        if (!hit)
        begin
            path_expected.push_back(NO_PATH);
        end
        else
        begin
            v = dst;
            guard = 0;
            while (v != int'(src) && guard < DPF_NODES)
            begin
                path_expected.push_back('{path_node: v[FIELD_W-1:0], found: 1'b1, last: 1'b0});
                v = pred_node[v];
                guard++;
            end
            path_expected.push_back('{path_node: src, found: 1'b1, last: 1'b1});
        end
    endtask

    task automatic apply_request(input logic cmd, input logic [FIELD_W-1:0] src,
                                 input logic [FIELD_W-1:0] dst, input logic present);
        if (cmd == CMD_EDGE)
        begin
            adjacency_rows[src][dst] = present;
        end
        else
        begin
            predict_path(src, dst);
        end
    endtask

    task automatic send_request(input logic cmd, input logic [FIELD_W-1:0] src,
                                input logic [FIELD_W-1:0] dst, input logic present,
                                input bit use_fixed, input path_step_t fixed_res);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= cmd;
        req_ch.from_node    <= src;
        req_ch.to_node      <= dst;
        req_ch.edge_present <= present;
        do @(posedge clk); while (!req_ch.ready);
        if (use_fixed)
        begin
            path_expected.push_back(fixed_res);
        end
        else
        begin
            apply_request(cmd, src, dst, present);
        end
    endtask

    // Holds off new requests until every queued result has come and an edge write has settled.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (path_expected.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(input logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        node_limit = value;
    endtask

    // Mostly nodes inside the active range, so that searches find real paths.
    function automatic logic [FIELD_W-1:0] pick_node();
        int span;
        span = (node_limit >= 4 && node_limit < DPF_NODES) ? int'(node_limit) : DPF_NODES;
        if ($urandom_range(0, 99) < 85)
        begin
            return FIELD_W'($urandom_range(0, span - 1));
        end
        return FIELD_W'($urandom_range(0, DPF_NODES - 1));
    endfunction

    // Result side: random back-pressure and the comparison against the oldest expectation.
    initial
    begin
        path_step_t want;
        int         stall;
        bit         calm;
        res_ch.ready <= 1'b0;
        calm = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                calm = !calm;
            end
            stall = calm ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            if (path_expected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result node %0d found %0d last %0d",
                                          res_ch.path_node, res_ch.found, res_ch.last));
            end
            else
            begin
                want = path_expected.pop_front();
                if (res_ch.path_node !== want.path_node)
                begin
                    report_mismatch($sformatf("path_node got %0d want %0d",
                                              res_ch.path_node, want.path_node));
                end
                if (res_ch.found !== want.found)
                begin
                    report_mismatch($sformatf("found got %0d want %0d",
                                              res_ch.found, want.found));
                end
                if (res_ch.last !== want.last)
                begin
                    report_mismatch($sformatf("last got %0d want %0d",
                                              res_ch.last, want.last));
                end
            end
        end
    end

    // Ends the run when neither channel has moved anything for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int                 roll;
        logic               cmd;
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] dst;
        logic               present;
        error_count = 0;
        send_calm   = 1'b0;
        node_limit  = NODE_COUNT_RST;
        for (int r = 0; r < DPF_NODES; r++)
        begin
            adjacency_rows[r] = '0;
            pred_node[r]      = '0;
        end
        phase_limits = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd12, 6'd20, NODE_COUNT_RST};
        phase_limits[5] = COUNT_W'($urandom_range(2, 31));

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_data            <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= CMD_EDGE;
        req_ch.from_node    <= '0;
        req_ch.to_node      <= '0;
        req_ch.edge_present <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
            begin
                write_node_count(directed_rows[i].limit);
            end
            else
            begin
                send_request(directed_rows[i].cmd, directed_rows[i].src, directed_rows[i].dst,
                             directed_rows[i].present, directed_rows[i].fixed,
                             directed_rows[i].result);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_node_count(phase_limits[p]);
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_calm = !send_calm;
                end
                if ($urandom_range(0, 32) == 0)
                begin
                    wait_idle();
                end
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    // Noise over the full range of every field.
                    cmd     = 1'($urandom_range(0, 1));
                    src     = FIELD_W'($urandom_range(0, DPF_NODES - 1));
                    dst     = FIELD_W'($urandom_range(0, DPF_NODES - 1));
                    present = 1'($urandom_range(0, 1));
                end
                else if (roll < 55)
                begin
                    cmd     = CMD_EDGE;
                    src     = pick_node();
                    dst     = pick_node();
                    present = ($urandom_range(0, 99) < 70);
                end
                else
                begin
                    cmd     = CMD_QUERY;
                    src     = pick_node();
                    dst     = ($urandom_range(0, 19) == 0) ? src : pick_node();
                    present = 1'($urandom_range(0, 1));
                end
                send_request(cmd, src, dst, present, CHECK_MODEL, NO_PATH);
            end
        end

        wait_idle();
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/dpf_pkg.sv
rtl/core/dpf_req_if.sv
rtl/core/dpf_res_if.sv
rtl/core/dpf_ram.sv
rtl/core/dpf_sequencer.sv
rtl/core/dpf_datapath.sv
rtl/core/dfs_path_finder_core.sv
rtl/core/dpf_checker.sv
test/tb.sv
